/* design/assert_macros.svh */
// Assertion macros shared by the keyframe interpolation RTL.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define AST_ALWAYS(lbl, clk, rst_n, prop, msg)
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/kpli_pkg.sv */
// Shared widths, codes and stream layout for the keyframe interpolation core.
// Depends on nothing.
package kpli_pkg;

	localparam int MAX_KEYS_DEF = 32;
	localparam int CNT_W        = 6;
	localparam int KEY_W        = 16;
	localparam int VAL_W        = 32;
	localparam int NUM_CH       = 3;
	localparam int VEC_W        = VAL_W * NUM_CH;
	localparam int FRAC_W       = 16;
	localparam int SLOT_W       = 5;
	localparam int STAT_W       = 2;

	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 96;

	localparam int IN_IDX_LSB = 0;
	localparam int IN_KEY_LSB = IN_IDX_LSB + SLOT_W;
	localparam int IN_VAL_LSB = IN_KEY_LSB + KEY_W;
	localparam int IN_QRY_LSB = IN_VAL_LSB + VEC_W;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [STAT_W-1:0] STAT_INTERP = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FIRST  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_LAST   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

endpackage

/* design/keyframe_piecewise_linear_interp_core.sv */
// Top level of the keyframe interpolation core: stream ports, sequencer, key and value RAMs.
// Depends on kpli_pkg, kpli_ram, kpli_div, kpli_lerp and assert_macros.svh.
//
//  Channel     Signals                               Carries
//  input       s_tvalid s_tready s_tdata s_tuser     load or query transaction
//  output      m_tvalid m_tready m_tdata m_tuser     interpolated value and status
//  key_count   key_count_wr_en key_count_wr_data     number of keys in use
//
// A load writes both RAMs at the accepting edge.
// A query scans the key RAM one key a cycle through its single read port, stopping
// at the first key above the query time or at the last key in use; a held value
// then passes S_HOLD_RD and S_HOLD_CAP, an interpolated one S_RD_HI, S_RD_LO, the
// serial divider in S_DIV and the lerp pipeline in S_LERP, before S_DONE.
// Reset clears the sequencer and key_count; the RAMs hold nothing valid until loaded.
// A finished result waits in the output register while the next transaction is taken.
`include "assert_macros.svh"

module keyframe_piecewise_linear_interp_core #(
	parameter int MAX_KEYS = kpli_pkg::MAX_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_index, key_time, key_value_x, key_value_y, key_value_z, query_time, zero pad
	input  logic [kpli_pkg::IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_x, out_y, out_z
	output logic [kpli_pkg::OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [kpli_pkg::STAT_W-1:0]     m_tuser,
	input  logic                            key_count_wr_en,
	input  logic [kpli_pkg::CNT_W-1:0]      key_count_wr_data
);
	import kpli_pkg::*;

	localparam int IDX_W = $clog2(MAX_KEYS);
	localparam int N_W   = $clog2(MAX_KEYS + 1);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SCAN     = 9'b000000010,
		S_HOLD_RD  = 9'b000000100,
		S_HOLD_CAP = 9'b000001000,
		S_RD_HI    = 9'b000010000,
		S_RD_LO    = 9'b000100000,
		S_DIV      = 9'b001000000,
		S_LERP     = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  key_count_q;
	logic [N_W-1:0]    n_cur;
	logic [N_W-1:0]    n_q;
	logic [N_W-1:0]    cnt_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pidx_q;
	logic [KEY_W-1:0]  q_q;
	logic [KEY_W-1:0]  prev_key_q;
	logic [IDX_W-1:0]  va_q;
	logic [VEC_W-1:0]  hi_q;
	logic [VEC_W-1:0]  res_data_q;
	logic [STAT_W-1:0] res_stat_q;
	logic              m_tvalid_q;
	logic [VEC_W-1:0]  m_tdata_q;
	logic [STAT_W-1:0] m_tuser_q;

	logic [SLOT_W-1:0] in_idx;
	logic [KEY_W-1:0]  in_key;
	logic [VEC_W-1:0]  in_val;
	logic [KEY_W-1:0]  in_qry;
	logic              acc;
	logic              ld_we;
	logic [KEY_W-1:0]  key_dout;
	logic [VEC_W-1:0]  val_dout;
	logic              found;
	logic              last;
	logic              first_hit;
	logic              div_start;
	logic              div_done;
	logic [FRAC_W-1:0] div_quot;
	logic              lerp_start;
	logic              lerp_valid;
	logic [VEC_W-1:0]  lerp_res;
	logic              out_load;

	assign in_idx = s_tdata[IN_IDX_LSB +: SLOT_W];
	assign in_key = s_tdata[IN_KEY_LSB +: KEY_W];
	assign in_val = s_tdata[IN_VAL_LSB +: VEC_W];
	assign in_qry = s_tdata[IN_QRY_LSB +: KEY_W];

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign ld_we    = acc && (s_tuser == FUNC_LOAD) && (32'(in_idx) < 32'(MAX_KEYS));
	assign n_cur    = (32'(key_count_q) > 32'(MAX_KEYS)) ? N_W'(MAX_KEYS) : N_W'(key_count_q);

	assign found     = pend_q && (key_dout > q_q);
	assign last      = pend_q && ((N_W'(pidx_q) + N_W'(1)) == n_q);
	assign first_hit = (pidx_q == '0);
	assign div_start = (state_q == S_SCAN) && found && !first_hit;
	assign lerp_start = (state_q == S_DIV) && div_done;
	assign out_load  = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	kpli_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_key_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (IDX_W'(in_idx)),
		.wdata (in_key),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (key_dout)
	);

	kpli_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KEYS)) u_val_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (IDX_W'(in_idx)),
		.wdata (in_val),
		.raddr (va_q),
		.rdata (val_dout)
	);

	kpli_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (q_q - prev_key_q),
		.den    (key_dout - prev_key_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	kpli_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lerp_start),
		.lo     (val_dout),
		.hi     (hi_q),
		.frac   (div_quot),
		.valid  (lerp_valid),
		.res    (lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
		end else if (key_count_wr_en) begin
			key_count_q <= key_count_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pidx_q     <= '0;
			n_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && (s_tuser == FUNC_QUERY)) begin
						n_q    <= n_cur;
						cnt_q  <= '0;
						pend_q <= 1'b0;
						state_q <= (n_cur == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (found) begin
						state_q <= first_hit ? S_HOLD_RD : S_RD_HI;
					end else if (last) begin
						state_q <= S_HOLD_RD;
					end else begin
						pend_q <= 1'b1;
						pidx_q <= cnt_q[IDX_W-1:0];
						cnt_q  <= cnt_q + N_W'(1);
					end
				end
				S_HOLD_RD:  state_q <= S_HOLD_CAP;
				S_HOLD_CAP: state_q <= S_DONE;
				S_RD_HI:    state_q <= S_RD_LO;
				S_RD_LO:    state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					if (lerp_valid) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= res_data_q;
			m_tuser_q <= res_stat_q;
		end
		unique case (state_q)
			S_IDLE: begin
				q_q        <= in_qry;
				res_data_q <= '0;
				res_stat_q <= STAT_EMPTY;
			end
			S_SCAN: begin
				if (pend_q && !found) begin
					prev_key_q <= key_dout;
				end
				if (found) begin
					va_q       <= pidx_q;
					res_stat_q <= first_hit ? STAT_FIRST : STAT_INTERP;
				end else if (last) begin
					va_q       <= pidx_q;
					res_stat_q <= STAT_LAST;
				end
			end
			S_HOLD_CAP: res_data_q <= val_dout;
			S_RD_HI:    va_q <= va_q - IDX_W'(1);
			S_RD_LO:    hi_q <= val_dout;
			S_LERP: begin
				if (lerp_valid) begin
					res_data_q <= lerp_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`AST_IMPLY(a_div_done_in_div, clk, arst_n, div_done, state_q == S_DIV, "stray divider done")
	`AST_IMPLY(a_lerp_in_lerp, clk, arst_n, lerp_valid, state_q == S_LERP, "stray lerp result")
	`AST_IMPLY(a_scan_in_range, clk, arst_n, state_q == S_SCAN && pend_q, N_W'(pidx_q) < n_q, "scan overrun")
	`AST_IMPLY(a_result_from_done, clk, arst_n, $rose(m_tvalid_q), $past(state_q) == S_DONE, "stray result")

endmodule

/* design/kpli_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module kpli_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/kpli_div.sv */
// Restoring divider producing the Q0.16 fraction (num << 16) / den, one bit a cycle.
// Depends on kpli_pkg; the caller guarantees num < den.
module kpli_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kpli_pkg::KEY_W-1:0]  num,
	input  logic [kpli_pkg::KEY_W-1:0]  den,
	output logic                        done,
	output logic [kpli_pkg::FRAC_W-1:0] quot
);
	import kpli_pkg::*;

	localparam int STEP_W = $clog2(FRAC_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [KEY_W-1:0]  rem_q;
	logic [KEY_W-1:0]  den_q;
	logic [FRAC_W-1:0] quot_q;
	logic [KEY_W:0]    rem_sh;
	logic              ge;
	logic [KEY_W-1:0]  rem_nx;

	always_comb begin
		rem_sh = {rem_q, 1'b0};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? KEY_W'(rem_sh - {1'b0, den_q}) : rem_sh[KEY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(FRAC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/kpli_lerp.sv */
// Three-stage lerp of three channels: difference, product with the fraction, rounded add.
// Depends on kpli_pkg.
module kpli_lerp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [kpli_pkg::VEC_W-1:0]  lo,
	input  logic [kpli_pkg::VEC_W-1:0]  hi,
	input  logic [kpli_pkg::FRAC_W-1:0] frac,
	output logic                        valid,
	output logic [kpli_pkg::VEC_W-1:0]  res
);
	import kpli_pkg::*;

	localparam int PROD_W = VAL_W + FRAC_W + 2;
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

	logic v_s1, v_s2, v_s3;
	logic [FRAC_W-1:0]        frac_s1;
	logic signed [VAL_W:0]    diff_s1 [NUM_CH];
	logic signed [VAL_W-1:0]  lo_s1   [NUM_CH];
	logic signed [VAL_W-1:0]  lo_s2   [NUM_CH];
	logic signed [PROD_W-1:0] prod_s2 [NUM_CH];
	logic signed [PROD_W-1:0] shf     [NUM_CH];
	logic [VEC_W-1:0]         res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			shf[c] = (prod_s2[c] + RND_HALF) >>> FRAC_W;
		end
	end

	always_ff @(posedge clk) begin
		frac_s1 <= frac;
		for (int c = 0; c < NUM_CH; c++) begin
			diff_s1[c] <= (VAL_W+1)'($signed(hi[c*VAL_W +: VAL_W]))
				- (VAL_W+1)'($signed(lo[c*VAL_W +: VAL_W]));
			lo_s1[c]   <= $signed(lo[c*VAL_W +: VAL_W]);
			prod_s2[c] <= diff_s1[c] * $signed({1'b0, frac_s1});
			lo_s2[c]   <= lo_s1[c];
			res_s3[c*VAL_W +: VAL_W] <= VAL_W'(lo_s2[c]) + shf[c][VAL_W-1:0];
		end
	end

	assign valid = v_s3;
	assign res   = res_s3;

endmodule
